// File: design/cpc_pkg.sv
// Shared constants and types of the complementary pastel color block.
`default_nettype none
package cpc_pkg;

	// Fixed-point layout: components hold FB fraction bits, 1.0 = 2^FB.
	localparam int FB  = 16;
	localparam int IOW = FB + 1;
	// Hue dividend and quotient width: values below 6.0 in sixths of a turn.
	localparam int DW  = FB + 3;
	localparam int QW  = DW;
	// Channel hue position width: values below 9.0 before wrapping.
	localparam int HW  = FB + 4;
	// Packed stream width: three components rounded up to whole bytes.
	localparam int TW  = ((3 * IOW + 7) / 8) * 8;

	localparam logic [IOW-1:0] FX_ONE     = IOW'(64'd1 << FB);
	localparam logic [IOW-1:0] FX_HALF    = IOW'(64'd1 << (FB - 1));
	localparam logic [IOW-1:0] PASTEL_LOW = IOW'((8 * (64'd1 << FB) + 5) / 10);
	localparam logic [IOW-1:0] PASTEL_SAT = IOW'((6 * (64'd1 << FB) + 10) / 20);
	localparam logic [HW-1:0]  H_ONE      = HW'(64'd1 << FB);
	localparam logic [HW-1:0]  H_TURN     = HW'(6 * (64'd1 << FB));

	// Item classified by the front end and held in the queue.
	typedef struct packed {
		logic [DW-1:0]  dividend;
		logic [IOW-1:0] divisor;
		logic [IOW-1:0] p;
		logic [IOW-1:0] q;
	} front_item_t;

	// Item leaving the hue divider.
	typedef struct packed {
		logic [QW-1:0]  hue;
		logic [IOW-1:0] p;
		logic [IOW-1:0] q;
	} div_item_t;

	// How one channel is produced from p and q.
	typedef enum logic [1:0] {
		CH_P    = 2'd0,
		CH_Q    = 2'd1,
		CH_RAMP = 2'd2
	} ch_mode_t;

endpackage
`default_nettype wire

// File: design/cpc_front.sv
// Front end: input saturation, max/min, hue dividend, lightness and p/q.
`default_nettype none
module cpc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [cpc_pkg::TW-1:0] in_data,
	output logic                 item_valid,
	input  wire                  item_ready,
	output cpc_pkg::front_item_t item
);
	import cpc_pkg::*;

	function automatic logic [IOW-1:0] sat_in(input logic [IOW-1:0] v);
		return (v > FX_ONE) ? FX_ONE : v;
	endfunction

	logic           en;
	logic [IOW-1:0] r, g, b, mx, mn, d;
	logic [DW-1:0]  dd, dvd;
	logic [IOW:0]   lsum;
	logic [IOW-1:0] light;
	logic           s1_valid, s2_valid;
	logic [DW-1:0]  dividend_s1, dividend_s2;
	logic [IOW-1:0] divisor_s1, divisor_s2, light_s1;
	logic [IOW-1:0] p_s2, q_s2;
	logic [2*IOW-1:0] prod;
	logic [IOW+1:0] qsum;
	logic [IOW-1:0] qv;

	assign en       = !s2_valid || item_ready;
	assign in_ready = en;

	// Saturate components, find extremes, build the sextant dividend and clamp the lightness.
	always_comb begin
		r  = sat_in(in_data[IOW-1:0]);
		g  = sat_in(in_data[2*IOW-1:IOW]);
		b  = sat_in(in_data[3*IOW-1:2*IOW]);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d  = mx - mn;
		dd = DW'(d);
		if (d == '0) begin
			dvd = '0;
		end else if (mx == r) begin
			if (g < b) dvd = (dd << 2) + (dd << 1) - DW'(b) + DW'(g);
			else       dvd = DW'(g) - DW'(b);
		end else if (mx == g) begin
			dvd = (dd << 1) + DW'(b) - DW'(r);
		end else begin
			dvd = (dd << 2) + DW'(r) - DW'(g);
		end
		lsum  = (IOW+1)'(mx) + (IOW+1)'(mn);
		light = lsum[IOW:1];
		if (light < PASTEL_LOW) light = PASTEL_LOW;
		if (light > FX_ONE)     light = FX_ONE;
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (en) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s1 <= dvd;
			divisor_s1  <= (d == '0) ? IOW'(1) : d;
			light_s1    <= light;
		end
	end

	// Pastel saturation applied to the clamped lightness.
	always_comb begin
		prod = (2*IOW)'(light_s1) * (2*IOW)'(PASTEL_SAT) + (2*IOW)'(FX_HALF);
		qsum = (IOW+2)'(light_s1) + (IOW+2)'(PASTEL_SAT) - (IOW+2)'(prod[2*IOW-1:FB]);
		qv   = (qsum > (IOW+2)'(FX_ONE)) ? FX_ONE : qsum[IOW-1:0];
	end

	// Stage two registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (en) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s2 <= dividend_s1;
			divisor_s2  <= divisor_s1;
			q_s2        <= qv;
			p_s2        <= (light_s1 << 1) - qv;
		end
	end

	assign item_valid    = s2_valid;
	assign item.dividend = dividend_s2;
	assign item.divisor  = divisor_s2;
	assign item.p        = p_s2;
	assign item.q        = q_s2;

endmodule
`default_nettype wire

// File: design/cpc_queue.sv
// Four-entry queue between the front end and the back end.
`default_nettype none
module cpc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  cpc_pkg::front_item_t push_item,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output cpc_pkg::front_item_t pop_item
);
	import cpc_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	front_item_t    slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			if (do_push && !do_pop)      count_q <= count_q + (AW+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (AW+1)'(1);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// File: design/cpc_div.sv
// Pipelined restoring divider for the hue, one quotient bit per stage.
`default_nettype none
module cpc_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  cpc_pkg::front_item_t in_item,
	output logic                 out_valid,
	output cpc_pkg::div_item_t   out_item
);
	import cpc_pkg::*;

	typedef struct packed {
		logic [IOW-1:0] rem;
		logic [IOW-1:0] dvs;
		logic [QW-1:0]  num;
		logic [QW-1:0]  quo;
		logic [IOW-1:0] p;
		logic [IOW-1:0] q;
	} div_stage_t;

	logic       vld_q [QW];
	div_stage_t stg_q [QW];
	div_stage_t load;

	// The top dividend bits start the remainder; the rest are shifted in.
	always_comb begin
		load.rem = IOW'(in_item.dividend[DW-1:QW-FB]);
		load.dvs = in_item.divisor;
		load.num = {in_item.dividend[QW-FB-1:0], FB'(0)};
		load.quo = '0;
		load.p   = in_item.p;
		load.q   = in_item.q;
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		div_stage_t src, nxt;
		logic       src_v;
		logic [IOW:0] cand;
		logic         ge;

		if (i == 0) begin : g_first
			assign src   = load;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stg_q[i-1];
			assign src_v = vld_q[i-1];
		end

		// One trial subtraction.
		always_comb begin
			cand     = {src.rem, src.num[QW-1]};
			ge       = cand >= {1'b0, src.dvs};
			nxt      = src;
			nxt.rem  = ge ? IOW'(cand - {1'b0, src.dvs}) : cand[IOW-1:0];
			nxt.num  = src.num << 1;
			nxt.quo  = {src.quo[QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) stg_q[i] <= nxt;
		end
	end

	assign out_valid    = vld_q[QW-1];
	assign out_item.hue = stg_q[QW-1].quo;
	assign out_item.p   = stg_q[QW-1].p;
	assign out_item.q   = stg_q[QW-1].q;

endmodule
`default_nettype wire

// File: design/cpc_back.sv
// Back end: hue rotation, HSL to RGB ramps, pastel clamp and output register.
`default_nettype none
module cpc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	output logic                  en,
	input  wire                   in_valid,
	input  cpc_pkg::div_item_t    in_item,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [cpc_pkg::TW-1:0] out_data
);
	import cpc_pkg::*;

	logic [HW-1:0]  h, t [3];
	ch_mode_t       mode [3];
	logic [IOW-1:0] x [3];
	logic           p1_valid, p2_valid, out_valid_q;
	ch_mode_t       mode_s1 [3];
	logic [IOW-1:0] x_s1 [3];
	logic [IOW-1:0] p_s1, q_s1;
	logic [IOW-1:0] c [3], c_s2 [3];
	logic [IOW-1:0] top;
	logic [IOW-1:0] res [3], res_q [3];

	assign en        = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Rotate the hue by a half turn and place each channel on its ramp.
	always_comb begin
		h = HW'(in_item.hue) + (H_ONE << 1) + H_ONE;
		if (h > H_TURN) h = h - H_TURN;
		t[0] = h + (H_ONE << 1);
		if (t[0] > H_TURN) t[0] = t[0] - H_TURN;
		t[1] = h;
		t[2] = (h < (H_ONE << 1)) ? h + (H_ONE << 2) : h - (H_ONE << 1);
		for (int k = 0; k < 3; k++) begin
			if (t[k] < H_ONE) begin
				mode[k] = CH_RAMP;
				x[k]    = IOW'(t[k]);
			end else if (t[k] < (H_ONE << 1) + H_ONE) begin
				mode[k] = CH_Q;
				x[k]    = '0;
			end else if (t[k] < (H_ONE << 2)) begin
				mode[k] = CH_RAMP;
				x[k]    = IOW'((H_ONE << 2) - t[k]);
			end else begin
				mode[k] = CH_P;
				x[k]    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_valid    <= 1'b0;
			p2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			p1_valid    <= in_valid;
			p2_valid    <= p1_valid;
			out_valid_q <= p2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			x_s1    <= x;
			p_s1    <= in_item.p;
			q_s1    <= in_item.q;
		end
	end

	// Ramp products, one multiplier per channel.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [2*IOW-1:0] prod;
			prod = (2*IOW)'(q_s1 - p_s1) * (2*IOW)'(x_s1[k]) + (2*IOW)'(FX_HALF);
			case (mode_s1[k])
				CH_RAMP: c[k] = p_s1 + IOW'(prod[2*IOW-1:FB]);
				CH_Q:    c[k] = q_s1;
				default: c[k] = p_s1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) c_s2 <= c;
	end

	// Largest components go to full scale, the rest are clamped.
	always_comb begin
		top = c_s2[0];
		if (c_s2[1] > top) top = c_s2[1];
		if (c_s2[2] > top) top = c_s2[2];
		for (int k = 0; k < 3; k++) begin
			if (c_s2[k] == top)           res[k] = FX_ONE;
			else if (c_s2[k] < PASTEL_LOW) res[k] = PASTEL_LOW;
			else if (c_s2[k] > FX_ONE)     res[k] = FX_ONE;
			else                           res[k] = c_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_q <= res;
	end

	assign out_data = TW'({res_q[2], res_q[1], res_q[0]});

endmodule
`default_nettype wire

// File: design/complementary_pastel_color.sv
// Path: front end registers, the queue, the hue divider stages, then the back end registers.
// Throughput: one pixel per clock unless m_tready stalls the 19-stage hue divider.
// A four-entry queue decouples the front end from the divider and back end.
// Reset: arst_n clears all valid bits and queue pointers asynchronously; data is not reset.
// Top level of the complementary pastel color block.
`default_nettype none
module complementary_pastel_color (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: red_in[16:0], green_in[33:17], blue_in[50:34], zero pad.
	input  wire [cpc_pkg::TW-1:0] s_tdata,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// Fields from bit 0: red_out[16:0], green_out[33:17], blue_out[50:34], zero pad.
	output logic [cpc_pkg::TW-1:0] m_tdata
);
	import cpc_pkg::*;

	logic        f_valid, f_ready, q_valid, d_valid, back_en;
	front_item_t f_item, q_item;
	div_item_t   d_item;

	cpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	cpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (back_en),
		.pop_item   (q_item)
	);

	cpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.out_valid (d_valid),
		.out_item  (d_item)
	);

	cpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (d_valid),
		.in_item   (d_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// File: tb/cpc_scoreboard.sv
// Scoreboard class that predicts complementary pastel pixels and checks the block's output.
`timescale 1ns / 1ps
class cpc_scoreboard;
	localparam int FBITS = cpc_pkg::FB;
	localparam int IOW   = cpc_pkg::IOW;
	typedef logic [IOW-1:0] comp_t;
	typedef struct packed {
		comp_t blue;
		comp_t green;
		comp_t red;
	} pixel_t;

	pixel_t pending_pixels[$];
	int     error_count;

	function new();
		error_count = 0;
	endfunction

	// Rounding fixed-point product, half rounds up.
	function longint unsigned fx_product(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << (FBITS - 1))) >> FBITS;
	endfunction

	// One channel of the HSL to RGB ramp; position in sixths of a turn.
	function longint unsigned channel_level(longint unsigned p, longint unsigned q, longint t);
		longint unsigned one;
		longint turn;
		one = 64'd1 << FBITS;
		turn = 6 * longint'(one);
		if (t < 0)
			t += turn;
		if (t > turn)
			t -= turn;
		if (t < longint'(one))
			return p + fx_product(q - p, longint'(t));
		if (t < 3 * longint'(one))
			return q;
		if (t < 4 * longint'(one))
			return p + fx_product(q - p, 4 * one - longint'(t));
		return p;
	endfunction

	// Works out the complementary pastel color of one pixel.
	function pixel_t pastel_of(pixel_t px);
		longint unsigned one, low, sat, c[3], mx, mn, d, dividend, hue, light, q, p, top;
		longint unsigned v;
		pixel_t res;
		one = 64'd1 << FBITS;
		low = (8 * one + 5) / 10;
		sat = (6 * one + 10) / 20;
		c[0] = (px.red > one) ? one : px.red;
		c[1] = (px.green > one) ? one : px.green;
		c[2] = (px.blue > one) ? one : px.blue;
		mx = c[0];
		mn = c[0];
		for (int i = 1; i < 3; i++) begin
			if (c[i] > mx) mx = c[i];
			if (c[i] < mn) mn = c[i];
		end
		d = mx - mn;
		hue = 0;
		if (d != 0) begin
			if (mx == c[0]) begin
				dividend = (c[1] < c[2]) ? 6 * d - (c[2] - c[1]) : c[1] - c[2];
			end else if (mx == c[1]) begin
				dividend = 2 * d + c[2] - c[0];
			end else begin
				dividend = 4 * d + c[0] - c[1];
			end
			hue = (dividend << FBITS) / d;
		end
		hue += 3 * one;
		if (hue > 6 * one)
			hue -= 6 * one;
		light = (mx + mn) >> 1;
		if (light < low) light = low;
		if (light > one) light = one;
		q = light + sat - fx_product(light, sat);
		if (q > one) q = one;
		p = 2 * light - q;
		c[0] = channel_level(p, q, longint'(hue) + 2 * longint'(one));
		c[1] = channel_level(p, q, longint'(hue));
		c[2] = channel_level(p, q, longint'(hue) - 2 * longint'(one));
		top = c[0];
		if (c[1] > top) top = c[1];
		if (c[2] > top) top = c[2];
		for (int i = 0; i < 3; i++) begin
			v = (c[i] == top) ? one : (c[i] < low ? low : (c[i] > one ? one : c[i]));
			c[i] = v;
		end
		res.red = comp_t'(c[0]);
		res.green = comp_t'(c[1]);
		res.blue = comp_t'(c[2]);
		return res;
	endfunction

	function void note_input(pixel_t px);
		pending_pixels.push_back(pastel_of(px));
	endfunction

	function void check_output(pixel_t got);
		pixel_t exp_px;
		if (pending_pixels.size() == 0) begin
			$error("output transfer with no pixel pending: %h", got);
			error_count++;
			return;
		end
		exp_px = pending_pixels.pop_front();
		if (got.red !== exp_px.red) begin
			$error("red_out expected %0d actual %0d", exp_px.red, got.red);
			error_count++;
		end
		if (got.green !== exp_px.green) begin
			$error("green_out expected %0d actual %0d", exp_px.green, got.green);
			error_count++;
		end
		if (got.blue !== exp_px.blue) begin
			$error("blue_out expected %0d actual %0d", exp_px.blue, got.blue);
			error_count++;
		end
	endfunction
endclass

// File: tb/tb_top.sv
// Top-level testbench of the complementary pastel color block.
`timescale 1ns / 1ps
module tb_top;
	localparam int TW = cpc_pkg::TW;
	localparam int IOW = cpc_pkg::IOW;
	localparam int RANDOM_PIXELS = 1100;
	localparam longint CYCLE_LIMIT = 200000;

	// Pixel as packed on the stream, red in the lowest bits.
	typedef struct packed {
		logic [IOW-1:0] blue;
		logic [IOW-1:0] green;
		logic [IOW-1:0] red;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TW-1:0] m_tdata;

	cpc_scoreboard pastel_board;
	bit calm_phase = 1'b0;
	longint cycle_count = 0;

	complementary_pastel_color dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: stalls in random bursts outside the calm phase, checks every output transfer.
	initial begin
		int stall;
		pastel_board = new();
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				pastel_board.check_output(pixel_t'(m_tdata[3*IOW-1:0]));
			if (!calm_phase && stall == 0 && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sends one pixel, with an optional random gap first, and holds it until taken.
	task automatic send_pixel(logic [IOW-1:0] r, logic [IOW-1:0] g, logic [IOW-1:0] b);
		pixel_t px;
		int gap;
		px.red = r;
		px.green = g;
		px.blue = b;
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TW'(px);
		do @(posedge clk); while (!s_tready);
		pastel_board.note_input(px);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly legal components, some above 1.0 or with the top bit set.
	function automatic logic [IOW-1:0] random_component();
		case ($urandom_range(0, 9))
			0: return IOW'($urandom);
			1: return IOW'(65536);
			2: return IOW'(0);
			3, 4: return IOW'($urandom_range(52000, 65536));
			default: return IOW'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic wait_drained();
		while (pastel_board.pending_pixels.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Stimulus: directed corners, then random pixels, then a calm tail.
	initial begin
		logic [IOW-1:0] g;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Greys, saturated primaries and secondaries, ties and overrange values.
		send_pixel(0, 0, 0);
		send_pixel(65536, 65536, 65536);
		send_pixel(30000, 30000, 30000);
		send_pixel(65536, 0, 0);
		send_pixel(0, 65536, 0);
		send_pixel(0, 0, 65536);
		send_pixel(65536, 65536, 0);
		send_pixel(0, 65536, 65536);
		send_pixel(65536, 0, 65536);
		send_pixel(65536, 0, 1);
		send_pixel(65536, 1, 0);
		send_pixel(1, 0, 0);
		send_pixel(131071, 131071, 131071);
		send_pixel(131071, 0, 70000);
		send_pixel(65537, 12345, 0);
		send_pixel(100, 40000, 65535);
		send_pixel(52429, 52428, 52430);
		send_pixel(65535, 32768, 32767);
		stop_sending();
		// Let everything drain once before the random part.
		wait_drained();
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i == RANDOM_PIXELS - 150)
				calm_phase = 1'b1;
			if (i % 5 == 0) begin
				g = random_component();
				send_pixel(g, g, g);
			end else begin
				send_pixel(random_component(), random_component(), random_component());
			end
		end
		stop_sending();
		wait_drained();
		if (pastel_board.error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
